// ===== src/pbp_pkg.sv =====
`timescale 1ns / 1ps

package pbp_pkg;

  // Field widths of the request and result items.
  localparam int COORD_W = 16;
  localparam int ANGLE_W = 16;
  localparam int NEAR_W  = 16;

  // Difference of two coordinates and its magnitude.
  localparam int DIFF_W = COORD_W + 1;
  localparam int MAG_W  = COORD_W;

  // CORDIC datapath: operands are normalized so that the larger one has its
  // leading one at NORM_MSB, and the angle runs on a 2^32-per-turn scale.
  localparam int STAGES    = 30;
  localparam int DATA_W    = 64;
  localparam int NORM_MSB  = 60;
  localparam int SHIFT_W   = 6;
  localparam int TURN_LOG2 = 32;
  localparam int TURN_W    = TURN_LOG2 + 1;
  localparam int Z_W       = TURN_LOG2 + 2;
  localparam int SQ_W      = 2 * NEAR_W;

  localparam logic [NEAR_W-1:0] NEAR_RESET = NEAR_W'(256);

  localparam logic [TURN_W-1:0] TURN_QUARTER  = TURN_W'(64'h0_4000_0000);
  localparam logic [TURN_W-1:0] TURN_HALF     = TURN_W'(64'h0_8000_0000);
  localparam logic [TURN_W-1:0] TURN_3QUARTER = TURN_W'(64'h0_C000_0000);
  localparam logic [TURN_W-1:0] TURN_FULL     = TURN_W'(64'h1_0000_0000);

  typedef struct packed {
    logic signed [COORD_W-1:0] own_x;
    logic signed [COORD_W-1:0] own_y;
    logic signed [COORD_W-1:0] other_x;
    logic signed [COORD_W-1:0] other_y;
  } pbp_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] bearing;
    logic               near;
  } pbp_out_t;

  // Quadrant and special-case information that rides along the CORDIC chain.
  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
    logic dx_neg;
    logic dy_neg;
    logic near;
  } pbp_side_t;

  // atan(2^-i) on the 2^32-per-turn scale.
  function automatic logic [31:0] atan_of(input int idx);
    logic [31:0] a;
    case (idx)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      24:      a = 32'h00000029;
      25:      a = 32'h00000014;
      26:      a = 32'h0000000A;
      27:      a = 32'h00000005;
      28:      a = 32'h00000003;
      29:      a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== src/pbp_front.sv =====
`timescale 1ns / 1ps

module pbp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                valid_i,
  input  pbp_pkg::pbp_in_t                    data_i,
  input  logic [pbp_pkg::NEAR_W-1:0]          near_thr,
  input  logic [pbp_pkg::SQ_W-1:0]            near_sq,
  output logic                                valid_o,
  output logic signed [pbp_pkg::DATA_W-1:0]   x_o,
  output logic signed [pbp_pkg::DATA_W-1:0]   y_o,
  output pbp_pkg::pbp_side_t                  side_o
);

  localparam int CMP_W = (pbp_pkg::MAG_W > pbp_pkg::NEAR_W) ? pbp_pkg::MAG_W : pbp_pkg::NEAR_W;
  localparam int SUM_W = pbp_pkg::SQ_W + 1;

  // Stage 1: coordinate differences.
  logic                                 v1_r;
  logic signed [pbp_pkg::DIFF_W-1:0]    dx1_r, dy1_r;

  // Stage 2: magnitudes and quadrant flags.
  logic                                 v2_r;
  logic [pbp_pkg::MAG_W-1:0]            ax2_r, ay2_r;
  logic                                 dxn2_r, dyn2_r, dxz2_r, dyz2_r;

  // Stage 3: normalization shift, squares and the coarse threshold test.
  logic                                 v3_r;
  logic [pbp_pkg::MAG_W-1:0]            ax3_r, ay3_r;
  logic [pbp_pkg::SHIFT_W-1:0]          sh3_r;
  logic [pbp_pkg::SQ_W-1:0]             sqx3_r, sqy3_r;
  logic                                 lt3_r;
  logic                                 dxn3_r, dyn3_r, dxz3_r, dyz3_r;

  // Stage 4: normalized operands and the near flag.
  logic                                 v4_r;
  logic signed [pbp_pkg::DATA_W-1:0]    x4_r, y4_r;
  pbp_pkg::pbp_side_t                   side4_r;

  logic [pbp_pkg::MAG_W-1:0]            m2;
  logic [pbp_pkg::SHIFT_W-1:0]          msb2;
  logic [pbp_pkg::NEAR_W-1:0]           ax2_n, ay2_n;
  logic [SUM_W-1:0]                     sum3;

  assign m2    = (ax2_r > ay2_r) ? ax2_r : ay2_r;
  assign ax2_n = pbp_pkg::NEAR_W'(ax2_r);
  assign ay2_n = pbp_pkg::NEAR_W'(ay2_r);
  assign sum3  = SUM_W'(sqx3_r) + SUM_W'(sqy3_r);

  always_comb begin
    msb2 = '0;
    for (int i = 0; i < pbp_pkg::MAG_W; i++) begin
      if (m2[i]) begin
        msb2 = pbp_pkg::SHIFT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1_r <= $signed({data_i.other_x[pbp_pkg::COORD_W-1], data_i.other_x})
             - $signed({data_i.own_x[pbp_pkg::COORD_W-1], data_i.own_x});
      dy1_r <= $signed({data_i.other_y[pbp_pkg::COORD_W-1], data_i.other_y})
             - $signed({data_i.own_y[pbp_pkg::COORD_W-1], data_i.own_y});

      ax2_r  <= pbp_pkg::MAG_W'(dx1_r[pbp_pkg::DIFF_W-1] ? -dx1_r : dx1_r);
      ay2_r  <= pbp_pkg::MAG_W'(dy1_r[pbp_pkg::DIFF_W-1] ? -dy1_r : dy1_r);
      dxn2_r <= dx1_r[pbp_pkg::DIFF_W-1];
      dyn2_r <= dy1_r[pbp_pkg::DIFF_W-1];
      dxz2_r <= (dx1_r == '0);
      dyz2_r <= (dy1_r == '0);

      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      sh3_r  <= pbp_pkg::SHIFT_W'(pbp_pkg::NORM_MSB) - msb2;
      sqx3_r <= ax2_n * ax2_n;
      sqy3_r <= ay2_n * ay2_n;
      // The near flag also needs both magnitudes below the threshold, alongside the squared-distance test.
      lt3_r  <= (CMP_W'(ax2_r) < CMP_W'(near_thr)) && (CMP_W'(ay2_r) < CMP_W'(near_thr));
      dxn3_r <= dxn2_r;
      dyn3_r <= dyn2_r;
      dxz3_r <= dxz2_r;
      dyz3_r <= dyz2_r;

      x4_r <= $signed(pbp_pkg::DATA_W'(ax3_r) << sh3_r);
      y4_r <= $signed(pbp_pkg::DATA_W'(ay3_r) << sh3_r);
      side4_r.dx_zero <= dxz3_r;
      side4_r.dy_zero <= dyz3_r;
      side4_r.dx_neg  <= dxn3_r;
      side4_r.dy_neg  <= dyn3_r;
      side4_r.near    <= lt3_r && (sum3 < SUM_W'(near_sq));
    end
  end

  assign valid_o = v4_r;
  assign x_o     = x4_r;
  assign y_o     = y4_r;
  assign side_o  = side4_r;

endmodule

// ===== src/pbp_cordic_stage.sv =====
`timescale 1ns / 1ps

module pbp_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                valid_i,
  input  logic signed [pbp_pkg::DATA_W-1:0]   x_i,
  input  logic signed [pbp_pkg::DATA_W-1:0]   y_i,
  input  logic signed [pbp_pkg::Z_W-1:0]      z_i,
  input  pbp_pkg::pbp_side_t                  side_i,
  output logic                                valid_o,
  output logic signed [pbp_pkg::DATA_W-1:0]   x_o,
  output logic signed [pbp_pkg::DATA_W-1:0]   y_o,
  output logic signed [pbp_pkg::Z_W-1:0]      z_o,
  output pbp_pkg::pbp_side_t                  side_o
);

  localparam logic signed [pbp_pkg::Z_W-1:0] ANG = pbp_pkg::Z_W'(pbp_pkg::atan_of(IDX));

  logic                                 valid_r;
  logic signed [pbp_pkg::DATA_W-1:0]    x_r, y_r;
  logic signed [pbp_pkg::Z_W-1:0]       z_r;
  pbp_pkg::pbp_side_t                   side_r;

  logic                                 y_neg;
  logic [pbp_pkg::DATA_W-1:0]           y_mag, y_sh;
  logic signed [pbp_pkg::DATA_W-1:0]    xs, ys;

  // x stays positive through vectoring; y is shifted by magnitude so that
  // negative values round toward zero.
  assign y_neg = y_i[pbp_pkg::DATA_W-1];
  assign y_mag = y_neg ? $unsigned(-y_i) : $unsigned(y_i);
  assign y_sh  = y_mag >> IDX;
  assign xs    = x_i >>> IDX;
  assign ys    = y_neg ? -$signed(y_sh) : $signed(y_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= side_i;
      if (!y_neg) begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + ANG;
      end else begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - ANG;
      end
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign side_o  = side_r;

endmodule

// ===== src/pair_bearing_and_proximity.sv =====
`timescale 1ns / 1ps

// Bearing and proximity for one robot pair per request. The block takes a new
// request every cycle while the result side does not stall, and returns one
// result per request, in order, through registered stages for difference,
// magnitude, normalization and squared-distance compare, a register for each
// of the 30 CORDIC vectoring iterations, a quadrant-folding register and a
// rounding step into the output register. The whole pipeline
// holds while a finished result waits to be taken, so in_ready follows the
// output register being empty or drained. The near threshold is written
// through the cfg port; write it only while no request is in flight.
module pair_bearing_and_proximity (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pbp_pkg::pbp_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pbp_pkg::pbp_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pbp_pkg::NEAR_W-1:0]   cfg_data
);

  localparam int DROP = pbp_pkg::TURN_LOG2 - pbp_pkg::ANGLE_W;

  logic                                 adv;
  logic [pbp_pkg::NEAR_W-1:0]           near_r;
  logic [pbp_pkg::SQ_W-1:0]             near_sq_r;

  logic [pbp_pkg::STAGES:0]             cv;
  logic signed [pbp_pkg::DATA_W-1:0]    cx [0:pbp_pkg::STAGES];
  logic signed [pbp_pkg::DATA_W-1:0]    cy [0:pbp_pkg::STAGES];
  logic signed [pbp_pkg::Z_W-1:0]       cz [0:pbp_pkg::STAGES];
  pbp_pkg::pbp_side_t                   cs [0:pbp_pkg::STAGES];

  logic                                 fold_v_r;
  logic [pbp_pkg::TURN_W-1:0]           fold_r;
  logic                                 fold_near_r;
  logic [pbp_pkg::TURN_W-1:0]           quad_a, fold_nxt;
  logic signed [pbp_pkg::Z_W-1:0]       z_end;
  pbp_pkg::pbp_side_t                   s_end;

  logic                                 out_valid_r;
  pbp_pkg::pbp_out_t                    out_data_r;
  logic [pbp_pkg::TURN_W-1:0]           rnd;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= pbp_pkg::NEAR_RESET;
    end else if (cfg_valid) begin
      near_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    near_sq_r <= near_r * near_r;
  end

  pbp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .valid_i  (in_valid),
    .data_i   (in_data),
    .near_thr (near_r),
    .near_sq  (near_sq_r),
    .valid_o  (cv[0]),
    .x_o      (cx[0]),
    .y_o      (cy[0]),
    .side_o   (cs[0])
  );

  assign cz[0] = '0;

  for (genvar g = 0; g < pbp_pkg::STAGES; g++) begin : g_cordic
    pbp_cordic_stage #(
      .IDX (g)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (cv[g]),
      .x_i     (cx[g]),
      .y_i     (cy[g]),
      .z_i     (cz[g]),
      .side_i  (cs[g]),
      .valid_o (cv[g+1]),
      .x_o     (cx[g+1]),
      .y_o     (cy[g+1]),
      .z_o     (cz[g+1]),
      .side_o  (cs[g+1])
    );
  end

  assign z_end = cz[pbp_pkg::STAGES];
  assign s_end = cs[pbp_pkg::STAGES];

  // Clamp the first-quadrant angle, then place it in its quadrant; points on an axis get their angle directly.
  always_comb begin
    if (z_end < 0) begin
      quad_a = '0;
    end else if (z_end > $signed(pbp_pkg::Z_W'(pbp_pkg::TURN_QUARTER))) begin
      quad_a = pbp_pkg::TURN_QUARTER;
    end else begin
      quad_a = pbp_pkg::TURN_W'(z_end);
    end

    if (s_end.dx_zero) begin
      fold_nxt = s_end.dy_neg ? pbp_pkg::TURN_3QUARTER : pbp_pkg::TURN_QUARTER;
    end else if (s_end.dy_zero) begin
      fold_nxt = s_end.dx_neg ? pbp_pkg::TURN_HALF : '0;
    end else if (s_end.dx_neg && !s_end.dy_neg) begin
      fold_nxt = pbp_pkg::TURN_HALF - quad_a;
    end else if (s_end.dx_neg) begin
      fold_nxt = pbp_pkg::TURN_HALF + quad_a;
    end else if (s_end.dy_neg) begin
      fold_nxt = pbp_pkg::TURN_FULL - quad_a;
    end else begin
      fold_nxt = quad_a;
    end
  end

  // A full turn rounds into bit TURN_LOG2 and drops out, which wraps to zero.
  assign rnd = fold_r + (pbp_pkg::TURN_W'(1) << (DROP - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      fold_v_r    <= cv[pbp_pkg::STAGES];
      out_valid_r <= fold_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fold_r              <= fold_nxt;
      fold_near_r         <= s_end.near;
      out_data_r.bearing  <= rnd[DROP +: pbp_pkg::ANGLE_W];
      out_data_r.near     <= fold_near_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_near_needs_threshold: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.near) |-> (near_r != '0)
  ) else $error("near flag set with a zero threshold");

  a_stall_freezes_pipe: assert property (
    @(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(cv) && $stable(fold_v_r))
  ) else $error("pipeline valid bits moved during a stall");

  a_result_from_fold: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fold_v_r)
  ) else $error("result appeared without a folded angle behind it");

endmodule
